// ===== hdl/longest_line_tracker_defines.svh =====
// Assertion macros shared by the longest line tracker RTL.
`ifndef LONGEST_LINE_TRACKER_DEFINES_SVH
`define LONGEST_LINE_TRACKER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define LLT_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("longest line tracker: assertion failed");

// A condition that implies another in the same cycle.
`define LLT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("longest line tracker: assertion failed");

// A condition that implies another in the next cycle.
`define LLT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("longest line tracker: assertion failed");

`endif

// ===== hdl/llt_pkg.sv =====
// Types, constants and request codes of the longest line tracker.
package llt_pkg;

  localparam int MAX_LINES   = 4096;
  localparam int COUNT_BITS  = 16;
  localparam int LINE_W      = $clog2(MAX_LINES);
  localparam int TOTAL_W     = $clog2(MAX_LINES + 1);
  localparam int WEIGHT_W    = 8;
  localparam int LEN_W       = COUNT_BITS + WEIGHT_W;
  localparam int PORT_LINE_W = 12;
  localparam int PORT_CNT_W  = 16;
  localparam int OUT_LEN_W   = 24;
  localparam int REQ_W       = 3;
  localparam int STAT_W      = 2;
  localparam int EXT_W       = ((TOTAL_W > PORT_LINE_W) ? TOTAL_W : PORT_LINE_W) + 1;
  localparam int ENTRY_W     = 2 * COUNT_BITS;

  typedef logic [LINE_W-1:0]     line_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [EXT_W-1:0]      ext_t;

  localparam logic [REQ_W-1:0] REQ_RESET   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EDIT    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_METRIC  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LONGEST = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TABQ    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_EDIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MET_FOLD,
    ST_SCAN,
    ST_SCAN_END,
    ST_TABQ,
    ST_SH_RD,
    ST_SH_WR,
    ST_FILL
  } llt_state_e;

  // Tag that travels with a length through the weighting stage.
  typedef struct packed {
    logic  vld;
    line_t idx;
  } wtag_t;

  // The remembered maximum.
  typedef struct packed {
    line_t idx;
    len_t  len;
    logic  dirty;
  } maxrec_t;

endpackage

// ===== hdl/llt_ram.sv =====
// Simple dual-port line table memory with a registered read port.
module llt_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== hdl/llt_weigh.sv =====
// Registered weighting stage: chars plus tabs times (weight minus one).
module llt_weigh (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  llt_pkg::wtag_t                  tag_i,
  input  llt_pkg::cnt_t                   chars_i,
  input  llt_pkg::cnt_t                   tabs_i,
  input  logic [llt_pkg::WEIGHT_W-1:0]    weight_i,
  output llt_pkg::wtag_t                  tag_o,
  output llt_pkg::len_t                   len_o
);

  llt_pkg::len_t  len_d, len_q;
  llt_pkg::wtag_t tag_q;
  logic [llt_pkg::WEIGHT_W-1:0] extra;

  always_comb begin
    extra = weight_i - llt_pkg::WEIGHT_W'(1);
    len_d = llt_pkg::LEN_W'(chars_i)
          + llt_pkg::LEN_W'(tabs_i) * llt_pkg::LEN_W'(extra);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  assign tag_o = tag_q;
  assign len_o = len_q;

endmodule

// ===== hdl/longest_line_tracker.sv =====
// Top level of the longest line tracker: control sequencer, registers and line table.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  req_type_i .. query_line_i
//  out      output     out_valid_o / out_stall_i longest_length_o .. status_o
//
// One item is worked on at a time. Resets, unknown codes, rejected edits and
// longest queries with a clean maximum are answered from idle; line metrics pass
// a table write and weighting, then the fold; tab queries a table read. An edit
// reads and writes each moved line in turn, then writes each inserted line;
// a rescan reads the line_total table entries, one table read a cycle.
// Reset clears all control state; line 0 reads as zero until it is written,
// so no clearing pass is needed. A finished result waits in a holding register
// so the next transaction may be accepted while the output is stalled.
module longest_line_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [llt_pkg::REQ_W-1:0]         req_type_i,
  input  logic [llt_pkg::PORT_LINE_W-1:0]   first_line_i,
  input  logic [llt_pkg::PORT_LINE_W-1:0]   old_last_line_i,
  input  logic [llt_pkg::PORT_LINE_W-1:0]   new_last_line_i,
  input  logic [llt_pkg::PORT_CNT_W-1:0]    char_count_i,
  input  logic [llt_pkg::PORT_CNT_W-1:0]    tab_total_i,
  input  logic [llt_pkg::WEIGHT_W-1:0]      tab_weight_i,
  input  logic [llt_pkg::PORT_LINE_W-1:0]   query_line_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [llt_pkg::OUT_LEN_W-1:0]     longest_length_o,
  output logic [llt_pkg::PORT_LINE_W-1:0]   longest_line_o,
  output logic [llt_pkg::PORT_CNT_W-1:0]    tab_count_out_o,
  output logic [llt_pkg::STAT_W-1:0]        status_o
);

  `include "longest_line_tracker_defines.svh"

  // Folds the best re-measured line of an edit into the maximum.
  function automatic llt_pkg::maxrec_t fold(llt_pkg::maxrec_t cur, logic touched,
                                            llt_pkg::line_t bi, llt_pkg::len_t bw);
    llt_pkg::maxrec_t r;
    r = cur;
    if (!cur.dirty) begin
      if (touched) begin
        if (bw >= cur.len) begin
          r.idx = bi;
          r.len = bw;
        end else begin
          r.dirty = 1'b1;
        end
      end else if (bw > cur.len) begin
        r.idx = bi;
        r.len = bw;
      end
    end
    return r;
  endfunction

  llt_pkg::llt_state_e state_d, state_q;

  llt_pkg::total_t line_total_d, line_total_q;
  llt_pkg::line_t  max_idx_d, max_idx_q;
  llt_pkg::len_t   max_w_d, max_w_q;
  logic            dirty_d, dirty_q;
  logic [llt_pkg::WEIGHT_W-1:0] weight_d, weight_q;
  llt_pkg::line_t  cursor_d, cursor_q;
  llt_pkg::line_t  end_d, end_q;
  llt_pkg::line_t  best_idx_d, best_idx_q;
  llt_pkg::len_t   best_w_d, best_w_q;
  logic            open_d, open_q;
  logic            touched_d, touched_q;
  logic            zero0_d, zero0_q;

  logic            sh_up_d, sh_up_q;
  llt_pkg::line_t  sh_dist_d, sh_dist_q;
  llt_pkg::line_t  sh_src_d, sh_src_q;
  llt_pkg::total_t sh_left_d, sh_left_q;
  llt_pkg::line_t  fill_d, fill_q;
  llt_pkg::line_t  fill_end_d, fill_end_q;
  llt_pkg::total_t scan_k_d, scan_k_q;

  logic            rd_vld_q, rd_zero_q;
  llt_pkg::line_t  rd_idx_q;

  logic            pend_vld_d, pend_vld_q;
  logic [llt_pkg::OUT_LEN_W-1:0]   pend_len_d, pend_len_q;
  logic [llt_pkg::PORT_LINE_W-1:0] pend_line_d, pend_line_q;
  logic [llt_pkg::PORT_CNT_W-1:0]  pend_tab_d, pend_tab_q;
  logic [llt_pkg::STAT_W-1:0]      pend_stat_d, pend_stat_q;

  logic            out_valid_q;
  logic [llt_pkg::OUT_LEN_W-1:0]   out_len_q;
  logic [llt_pkg::PORT_LINE_W-1:0] out_line_q;
  logic [llt_pkg::PORT_CNT_W-1:0]  out_tab_q;
  logic [llt_pkg::STAT_W-1:0]      out_stat_q;
  logic            out_free;

  logic                          ram_we, ram_re;
  llt_pkg::line_t                ram_waddr, ram_raddr;
  logic [llt_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  llt_pkg::cnt_t                 rd_chars, rd_tabs;

  llt_pkg::wtag_t w_tag_in, w_tag_out;
  llt_pkg::cnt_t  w_chars, w_tabs;
  llt_pkg::len_t  w_len;

  logic in_accept;
  llt_pkg::cnt_t in_chars, in_tabs;
  llt_pkg::ext_t first_e, old_e, new_e, total_e, newtot_e, tail_e, query_e;
  logic edit_bad, edit_moves, edit_grow, metric_ok, tabq_ok, lq_dirty;
  logic [llt_pkg::WEIGHT_W-1:0] tw_eff;
  logic scan_in;

  // ---------------------------------------------------------------------
  // Request decode shared by the sequencer and the datapath.
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != llt_pkg::ST_IDLE) || pend_vld_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_chars = llt_pkg::COUNT_BITS'(char_count_i);
  assign in_tabs  = llt_pkg::COUNT_BITS'(tab_total_i);

  always_comb begin
    first_e  = llt_pkg::EXT_W'(first_line_i);
    old_e    = llt_pkg::EXT_W'(old_last_line_i);
    new_e    = llt_pkg::EXT_W'(new_last_line_i);
    total_e  = llt_pkg::EXT_W'(line_total_q);
    query_e  = llt_pkg::EXT_W'(query_line_i);
    newtot_e = total_e + new_e - old_e;
    tail_e   = total_e - old_e - llt_pkg::EXT_W'(1);
    edit_bad = (old_e >= total_e) || (newtot_e > llt_pkg::EXT_W'(llt_pkg::MAX_LINES));
    // Lines behind the edited range must move when the range changes size.
    edit_moves = (tail_e != '0) && (new_e != old_e);
    edit_grow  = new_e > old_e;
    metric_ok  = open_q && (llt_pkg::TOTAL_W'(cursor_q) < line_total_q);
    tabq_ok    = query_e < total_e;
    tw_eff     = (tab_weight_i == '0) ? llt_pkg::WEIGHT_W'(1) : tab_weight_i;
    lq_dirty   = dirty_q || (tw_eff != weight_q);
    scan_in    = (state_q == llt_pkg::ST_SCAN) || (state_q == llt_pkg::ST_SCAN_END);
  end

  // ---------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      llt_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (req_type_i)
            llt_pkg::REQ_EDIT: begin
              if (!edit_bad && edit_moves) begin
                state_d = llt_pkg::ST_SH_RD;
              end else if (!edit_bad && edit_grow) begin
                state_d = llt_pkg::ST_FILL;
              end
            end
            llt_pkg::REQ_METRIC: begin
              if (metric_ok) begin
                state_d = llt_pkg::ST_MET_FOLD;
              end
            end
            llt_pkg::REQ_LONGEST: begin
              if (lq_dirty) begin
                state_d = llt_pkg::ST_SCAN;
              end
            end
            llt_pkg::REQ_TABQ: begin
              if (tabq_ok) begin
                state_d = llt_pkg::ST_TABQ;
              end
            end
            default: state_d = llt_pkg::ST_IDLE;
          endcase
        end
      end
      llt_pkg::ST_MET_FOLD: state_d = llt_pkg::ST_IDLE;
      llt_pkg::ST_SCAN: begin
        if (scan_k_q == line_total_q - llt_pkg::TOTAL_W'(1)) begin
          state_d = llt_pkg::ST_SCAN_END;
        end
      end
      llt_pkg::ST_SCAN_END: begin
        if (!rd_vld_q && !w_tag_out.vld) begin
          state_d = llt_pkg::ST_IDLE;
        end
      end
      llt_pkg::ST_TABQ:  state_d = llt_pkg::ST_IDLE;
      llt_pkg::ST_SH_RD: state_d = llt_pkg::ST_SH_WR;
      llt_pkg::ST_SH_WR: begin
        if (sh_left_q == llt_pkg::TOTAL_W'(1)) begin
          state_d = sh_up_q ? llt_pkg::ST_FILL : llt_pkg::ST_IDLE;
        end else begin
          state_d = llt_pkg::ST_SH_RD;
        end
      end
      llt_pkg::ST_FILL: begin
        if (fill_q == fill_end_q) begin
          state_d = llt_pkg::ST_IDLE;
        end
      end
      default: state_d = llt_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath, table port control and result staging.
  // ---------------------------------------------------------------------
  always_comb begin
    llt_pkg::maxrec_t mr;
    logic             dirty_n, touched_n, set_pend;
    llt_pkg::line_t   idx_n, bi;
    llt_pkg::len_t    bw;
    llt_pkg::line_t   first_l, old_l, new_l;

    first_l = llt_pkg::LINE_W'(first_line_i);
    old_l   = llt_pkg::LINE_W'(old_last_line_i);
    new_l   = llt_pkg::LINE_W'(new_last_line_i);

    line_total_d = line_total_q;
    max_idx_d    = max_idx_q;
    max_w_d      = max_w_q;
    dirty_d      = dirty_q;
    weight_d     = weight_q;
    cursor_d     = cursor_q;
    end_d        = end_q;
    best_idx_d   = best_idx_q;
    best_w_d     = best_w_q;
    open_d       = open_q;
    touched_d    = touched_q;
    zero0_d      = zero0_q;
    sh_up_d      = sh_up_q;
    sh_dist_d    = sh_dist_q;
    sh_src_d     = sh_src_q;
    sh_left_d    = sh_left_q;
    fill_d       = fill_q;
    fill_end_d   = fill_end_q;
    scan_k_d     = scan_k_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    w_tag_in = '0;
    w_chars  = in_chars;
    w_tabs   = in_tabs;

    set_pend    = 1'b0;
    pend_len_d  = '0;
    pend_line_d = '0;
    pend_tab_d  = '0;
    pend_stat_d = llt_pkg::STAT_OK;

    mr        = '0;
    dirty_n   = 1'b0;
    touched_n = 1'b0;
    idx_n     = '0;
    bi        = '0;
    bw        = '0;

    case (state_q)
      llt_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (req_type_i)
            llt_pkg::REQ_RESET: begin
              line_total_d = llt_pkg::TOTAL_W'(1);
              max_idx_d    = '0;
              max_w_d      = '0;
              dirty_d      = 1'b0;
              cursor_d     = '0;
              end_d        = '0;
              best_idx_d   = '0;
              best_w_d     = '0;
              open_d       = 1'b0;
              touched_d    = 1'b0;
              zero0_d      = 1'b1;
              set_pend     = 1'b1;
            end
            llt_pkg::REQ_EDIT: begin
              if (edit_bad) begin
                set_pend    = 1'b1;
                pend_stat_d = llt_pkg::STAT_RANGE;
              end else begin
                dirty_n   = dirty_q || open_q;
                touched_n = !dirty_n && (max_idx_q >= first_l) && (max_idx_q <= old_l);
                idx_n     = max_idx_q;
                if (!dirty_n && (max_idx_q > old_l)) begin
                  idx_n = max_idx_q - old_l + new_l;
                end
                line_total_d = llt_pkg::TOTAL_W'(newtot_e);
                best_idx_d   = first_l;
                best_w_d     = '0;
                cursor_d     = first_l;
                end_d        = new_l;
                // Nothing to re-measure: fold an empty measurement right away.
                if (first_e > new_e) begin
                  mr        = fold('{idx: idx_n, len: max_w_q, dirty: dirty_n}, touched_n,
                                   first_l, '0);
                  max_idx_d = mr.idx;
                  max_w_d   = mr.len;
                  dirty_d   = mr.dirty;
                  open_d    = 1'b0;
                  touched_d = 1'b0;
                end else begin
                  max_idx_d = idx_n;
                  dirty_d   = dirty_n;
                  open_d    = 1'b1;
                  touched_d = touched_n;
                end
                sh_up_d    = edit_grow;
                sh_dist_d  = edit_grow ? (new_l - old_l) : (old_l - new_l);
                sh_src_d   = edit_grow ? llt_pkg::LINE_W'(line_total_q - llt_pkg::TOTAL_W'(1))
                                       : (old_l + llt_pkg::LINE_W'(1));
                sh_left_d  = llt_pkg::TOTAL_W'(tail_e);
                fill_d     = old_l + llt_pkg::LINE_W'(1);
                fill_end_d = new_l;
                set_pend   = !edit_moves && !edit_grow;
              end
            end
            llt_pkg::REQ_METRIC: begin
              if (!metric_ok) begin
                set_pend    = 1'b1;
                pend_stat_d = llt_pkg::STAT_NO_EDIT;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cursor_q;
                ram_wdata = {in_chars, in_tabs};
                if (cursor_q == '0) begin
                  zero0_d = 1'b0;
                end
                w_tag_in = '{vld: 1'b1, idx: cursor_q};
              end
            end
            llt_pkg::REQ_LONGEST: begin
              weight_d = tw_eff;
              if (lq_dirty) begin
                max_idx_d = '0;
                max_w_d   = '0;
                scan_k_d  = '0;
              end else begin
                set_pend    = 1'b1;
                pend_len_d  = llt_pkg::OUT_LEN_W'(max_w_q);
                pend_line_d = llt_pkg::PORT_LINE_W'(max_idx_q);
              end
            end
            llt_pkg::REQ_TABQ: begin
              if (tabq_ok) begin
                ram_re    = 1'b1;
                ram_raddr = llt_pkg::LINE_W'(query_line_i);
              end else begin
                set_pend    = 1'b1;
                pend_stat_d = llt_pkg::STAT_RANGE;
              end
            end
            default: set_pend = 1'b1;
          endcase
        end
      end
      llt_pkg::ST_MET_FOLD: begin
        bi = best_idx_q;
        bw = best_w_q;
        if (w_len > best_w_q) begin
          bi = w_tag_out.idx;
          bw = w_len;
        end
        best_idx_d = bi;
        best_w_d   = bw;
        if (cursor_q >= end_q) begin
          mr        = fold('{idx: max_idx_q, len: max_w_q, dirty: dirty_q}, touched_q, bi, bw);
          max_idx_d = mr.idx;
          max_w_d   = mr.len;
          dirty_d   = mr.dirty;
          open_d    = 1'b0;
          touched_d = 1'b0;
        end else begin
          cursor_d = cursor_q + llt_pkg::LINE_W'(1);
        end
        set_pend = 1'b1;
      end
      llt_pkg::ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_k_q[llt_pkg::LINE_W-1:0];
        scan_k_d  = scan_k_q + llt_pkg::TOTAL_W'(1);
      end
      llt_pkg::ST_SCAN_END: begin
        if (!rd_vld_q && !w_tag_out.vld) begin
          // An open edit keeps the mark so its fold is skipped.
          dirty_d     = open_q;
          set_pend    = 1'b1;
          pend_len_d  = llt_pkg::OUT_LEN_W'(max_w_q);
          pend_line_d = llt_pkg::PORT_LINE_W'(max_idx_q);
        end
      end
      llt_pkg::ST_TABQ: begin
        set_pend   = 1'b1;
        pend_tab_d = llt_pkg::PORT_CNT_W'(rd_tabs);
      end
      llt_pkg::ST_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sh_src_q;
      end
      llt_pkg::ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_up_q ? (sh_src_q + sh_dist_q) : (sh_src_q - sh_dist_q);
        ram_wdata = {rd_chars, rd_tabs};
        sh_src_d  = sh_up_q ? (sh_src_q - llt_pkg::LINE_W'(1))
                            : (sh_src_q + llt_pkg::LINE_W'(1));
        sh_left_d = sh_left_q - llt_pkg::TOTAL_W'(1);
        if ((sh_left_q == llt_pkg::TOTAL_W'(1)) && !sh_up_q) begin
          set_pend = 1'b1;
        end
      end
      llt_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        ram_wdata = '0;
        fill_d    = fill_q + llt_pkg::LINE_W'(1);
        if (fill_q == fill_end_q) begin
          set_pend = 1'b1;
        end
      end
      default: set_pend = 1'b0;
    endcase

    // Rescan pipeline: table read, weighting, then compare against the maximum.
    if (scan_in && rd_vld_q) begin
      w_tag_in = '{vld: 1'b1, idx: rd_idx_q};
      w_chars  = rd_chars;
      w_tabs   = rd_tabs;
    end
    if (scan_in && w_tag_out.vld && (w_len > max_w_q)) begin
      max_w_d   = w_len;
      max_idx_d = w_tag_out.idx;
    end

    if (set_pend) begin
      pend_vld_d = 1'b1;
    end else if (pend_vld_q && out_free) begin
      pend_vld_d = 1'b0;
    end else begin
      pend_vld_d = pend_vld_q;
    end
  end

  // Line 0 reads as zero until it is written after a reset.
  assign rd_chars = rd_zero_q ? '0 : ram_rdata[llt_pkg::ENTRY_W-1:llt_pkg::COUNT_BITS];
  assign rd_tabs  = rd_zero_q ? '0 : ram_rdata[llt_pkg::COUNT_BITS-1:0];

  llt_ram #(
    .DEPTH (llt_pkg::MAX_LINES),
    .WIDTH (llt_pkg::ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  llt_weigh u_weigh (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (w_tag_in),
    .chars_i  (w_chars),
    .tabs_i   (w_tabs),
    .weight_i (weight_q),
    .tag_o    (w_tag_out),
    .len_o    (w_len)
  );

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= llt_pkg::ST_IDLE;
      line_total_q <= llt_pkg::TOTAL_W'(1);
      max_idx_q    <= '0;
      max_w_q      <= '0;
      dirty_q      <= 1'b0;
      weight_q     <= llt_pkg::WEIGHT_W'(1);
      cursor_q     <= '0;
      end_q        <= '0;
      best_idx_q   <= '0;
      best_w_q     <= '0;
      open_q       <= 1'b0;
      touched_q    <= 1'b0;
      zero0_q      <= 1'b1;
      sh_up_q      <= 1'b0;
      sh_left_q    <= '0;
      scan_k_q     <= '0;
      rd_vld_q     <= 1'b0;
      rd_zero_q    <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_total_q <= line_total_d;
      max_idx_q    <= max_idx_d;
      max_w_q      <= max_w_d;
      dirty_q      <= dirty_d;
      weight_q     <= weight_d;
      cursor_q     <= cursor_d;
      end_q        <= end_d;
      best_idx_q   <= best_idx_d;
      best_w_q     <= best_w_d;
      open_q       <= open_d;
      touched_q    <= touched_d;
      zero0_q      <= zero0_d;
      sh_up_q      <= sh_up_d;
      sh_left_q    <= sh_left_d;
      scan_k_q     <= scan_k_d;
      rd_vld_q     <= ram_re;
      rd_zero_q    <= ram_re && (ram_raddr == '0) && zero0_q;
      pend_vld_q   <= pend_vld_d;
      if (out_free) begin
        out_valid_q <= pend_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_dist_q  <= sh_dist_d;
    sh_src_q   <= sh_src_d;
    fill_q     <= fill_d;
    fill_end_q <= fill_end_d;
    rd_idx_q   <= ram_raddr;
    if (state_q != llt_pkg::ST_IDLE || in_accept) begin
      pend_len_q  <= pend_len_d;
      pend_line_q <= pend_line_d;
      pend_tab_q  <= pend_tab_d;
      pend_stat_q <= pend_stat_d;
    end
    if (out_free && pend_vld_q) begin
      out_len_q  <= pend_len_q;
      out_line_q <= pend_line_q;
      out_tab_q  <= pend_tab_q;
      out_stat_q <= pend_stat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign longest_length_o = out_len_q;
  assign longest_line_o   = out_line_q;
  assign tab_count_out_o  = out_tab_q;
  assign status_o         = out_stat_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `LLT_ASSERT_IMP(a_busy_no_pend, state_q != llt_pkg::ST_IDLE, !pend_vld_q)
  `LLT_ASSERT(a_total_range, (line_total_q != '0) && (line_total_q <= llt_pkg::TOTAL_W'(llt_pkg::MAX_LINES)))
  `LLT_ASSERT_IMP(a_open_cursor, open_q, cursor_q <= end_q)
  `LLT_ASSERT_NEXT(a_fold_one_cycle, state_q == llt_pkg::ST_MET_FOLD, (state_q == llt_pkg::ST_IDLE) && pend_vld_q)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the longest line tracker: directed table, then random edit sessions.
//
// Every accepted input transaction is run through a predictor of the line table
// held here, and the predicted answer is queued. Every accepted output
// transaction is compared field by field with the oldest queued answer. The
// directed rows cover the field extremes, every request code and the corner
// cases of the tracker; a few rows carry a typed answer that is obvious from
// the request. The random part is mostly well-formed edit sessions (an edit
// begin followed by the line metrics it asks for) on small tables, mixed with
// queries, reset requests, broken sessions and raw noise.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llt_pkg::*;

  localparam int IDLE_LIMIT = 50000;
  localparam int RANDOM_ITEMS = 1000;

  // One input transaction, one field per port.
  typedef struct packed {
    logic [REQ_W-1:0]       req;
    logic [PORT_LINE_W-1:0] first;
    logic [PORT_LINE_W-1:0] old_last;
    logic [PORT_LINE_W-1:0] new_last;
    logic [PORT_CNT_W-1:0]  chars;
    logic [PORT_CNT_W-1:0]  tabs;
    logic [WEIGHT_W-1:0]    weight;
    logic [PORT_LINE_W-1:0] qline;
  } request_t;

  // One output transaction.
  typedef struct packed {
    logic [OUT_LEN_W-1:0]   len;
    logic [PORT_LINE_W-1:0] line;
    logic [PORT_CNT_W-1:0]  tabs;
    logic [STAT_W-1:0]      status;
  } answer_t;

  // A directed row; the answer is used only when typed is set.
  typedef struct packed {
    request_t rq;
    logic     typed;
    answer_t  ans;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  request_t drv = '0;
  answer_t got;

  answer_t   answers_due[$];
  stim_row_t stim_rows[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        answers_seen = 0;
  int        edits_opened = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  // Predictor state: the line table and the remembered maximum.
  bit [15:0]       chr_tbl[MAX_LINES];
  bit [15:0]       tab_tbl[MAX_LINES];
  int unsigned     line_cnt;
  int unsigned     best_line;
  longint unsigned best_len;
  bit              best_dirty;
  int unsigned     weight_cur;
  int unsigned     cursor;
  int unsigned     cursor_end;
  int unsigned     edit_top_line;
  longint unsigned edit_top_len;
  bit              edit_open;
  bit              edit_touched;

  always #2 clk = ~clk;

  longest_line_tracker uut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (drv.req),
    .first_line_i    (drv.first),
    .old_last_line_i (drv.old_last),
    .new_last_line_i (drv.new_last),
    .char_count_i    (drv.chars),
    .tab_total_i     (drv.tabs),
    .tab_weight_i    (drv.weight),
    .query_line_i    (drv.qline),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .longest_length_o(got.len),
    .longest_line_o  (got.line),
    .tab_count_out_o (got.tabs),
    .status_o        (got.status)
  );

  function automatic longint unsigned weigh_line(int unsigned c, int unsigned t);
    return longint'(c) + longint'(t) * longint'(weight_cur - 1);
  endfunction

  function automatic void clear_lines();
    for (int k = 0; k < MAX_LINES; k++) begin
      chr_tbl[k] = '0;
      tab_tbl[k] = '0;
    end
    line_cnt = 1;
    best_line = 0;
    best_len = 0;
    best_dirty = 1'b0;
    cursor = 0;
    cursor_end = 0;
    edit_top_line = 0;
    edit_top_len = 0;
    edit_open = 1'b0;
    edit_touched = 1'b0;
  endfunction

  function automatic void rescan_lines();
    longint unsigned w;
    best_line = 0;
    best_len = 0;
    for (int unsigned k = 0; k < line_cnt; k++) begin
      w = weigh_line(chr_tbl[k], tab_tbl[k]);
      if (w > best_len) begin
        best_len = w;
        best_line = k;
      end
    end
    best_dirty = 1'b0;
  endfunction

  // Merges the best re-measured line of a finished edit into the maximum.
  function automatic void merge_edit();
    if (best_dirty) return;
    if (edit_touched) begin
      if (edit_top_len >= best_len) begin
        best_line = edit_top_line;
        best_len = edit_top_len;
      end else begin
        best_dirty = 1'b1;
      end
    end else if (edit_top_len > best_len) begin
      best_line = edit_top_line;
      best_len = edit_top_len;
    end
  endfunction

  function automatic logic [STAT_W-1:0] start_edit(int unsigned f, int unsigned o,
                                                    int unsigned n);
    int unsigned tail;
    int unsigned gap;
    int unsigned total_next;
    if (o >= line_cnt) return STAT_RANGE;
    total_next = line_cnt + n - o;
    if (total_next > MAX_LINES) return STAT_RANGE;
    if (edit_open) best_dirty = 1'b1;
    edit_open = 1'b0;
    edit_touched = 1'b0;
    tail = line_cnt - (o + 1);
    if (n > o) begin
      gap = n - o;
      for (int k = int'(tail) - 1; k >= 0; k--) begin
        chr_tbl[o + 1 + gap + k] = chr_tbl[o + 1 + k];
        tab_tbl[o + 1 + gap + k] = tab_tbl[o + 1 + k];
      end
      for (int unsigned k = 0; k < gap; k++) begin
        chr_tbl[o + 1 + k] = '0;
        tab_tbl[o + 1 + k] = '0;
      end
    end else if (o > n) begin
      for (int unsigned k = 0; k < tail; k++) begin
        chr_tbl[n + 1 + k] = chr_tbl[o + 1 + k];
        tab_tbl[n + 1 + k] = tab_tbl[o + 1 + k];
      end
    end
    line_cnt = total_next;
    if (!best_dirty && best_line >= f && best_line <= o) edit_touched = 1'b1;
    if (!best_dirty && best_line > o) best_line = best_line - o + n;
    edit_top_line = f;
    edit_top_len = 0;
    cursor = f;
    cursor_end = n;
    if (f > n) begin
      merge_edit();
      edit_touched = 1'b0;
    end else begin
      edit_open = 1'b1;
    end
    return STAT_OK;
  endfunction

  // Applies one request to the predicted table and returns the expected answer.
  function automatic answer_t track_request(request_t rq);
    answer_t a;
    longint unsigned w;
    int unsigned tw;
    a = '0;
    case (rq.req)
      REQ_RESET: clear_lines();
      REQ_EDIT: a.status = start_edit(rq.first, rq.old_last, rq.new_last);
      REQ_METRIC: begin
        if (!edit_open || cursor >= line_cnt) begin
          a.status = STAT_NO_EDIT;
        end else begin
          chr_tbl[cursor] = rq.chars;
          tab_tbl[cursor] = rq.tabs;
          w = weigh_line(rq.chars, rq.tabs);
          if (w > edit_top_len) begin
            edit_top_len = w;
            edit_top_line = cursor;
          end
          if (cursor >= cursor_end) begin
            merge_edit();
            edit_open = 1'b0;
            edit_touched = 1'b0;
          end else begin
            cursor++;
          end
        end
      end
      REQ_LONGEST: begin
        tw = (rq.weight == 0) ? 1 : rq.weight;
        if (tw != weight_cur) begin
          weight_cur = tw;
          best_dirty = 1'b1;
        end
        if (best_dirty) begin
          rescan_lines();
          // An open edit keeps the maximum suspect until the next query.
          if (edit_open) best_dirty = 1'b1;
        end
        a.len = best_len[OUT_LEN_W-1:0];
        a.line = best_line[PORT_LINE_W-1:0];
      end
      REQ_TABQ: begin
        if (rq.qline < line_cnt) a.tabs = tab_tbl[rq.qline];
        else a.status = STAT_RANGE;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one request, waits for the handshake, then predicts its answer.
  // A typed answer from the directed table replaces the predicted one.
  task automatic send(request_t rq, bit typed = 1'b0, answer_t typed_ans = '0);
    answer_t a;
    int gap;
    drv <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    a = track_request(rq);
    answers_due.push_back(typed ? typed_ans : a);
    items_sent++;
    if (rq.req == REQ_EDIT && edit_open) edits_opened++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic request_t noise_request();
    request_t rq;
    rq = {$urandom, $urandom, $urandom};
    return rq;
  endfunction

  function automatic logic [PORT_CNT_W-1:0] pick_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 40);
      2: return $urandom_range(65500, 65535);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return weight_cur[WEIGHT_W-1:0];
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic add_row(logic [REQ_W-1:0] req, int f, int o, int n, int c, int t, int w,
                         int q, bit typed = 1'b0, int len = 0, int line = 0, int tabs = 0,
                         logic [STAT_W-1:0] st = STAT_OK);
    stim_row_t r;
    r.rq = '{req, f, o, n, c, t, w, q};
    r.typed = typed;
    r.ans = '{len, line, tabs, st};
    stim_rows.push_back(r);
  endtask

  // One random edit session: an edit begin, then the metrics it opens (sometimes cut
  // short or one too many), with queries mixed in. Tables stay small apart from rare large edits.
  task automatic edit_session();
    request_t rq;
    int unsigned cap, hi, o, n, f, cnt;
    rq = noise_request();
    cap = ($urandom_range(0, 60) == 0) ? MAX_LINES : 48;
    o = $urandom_range(0, line_cnt - 1);
    hi = (cap > line_cnt) ? o + cap - line_cnt : o;
    if (hi > 4095) hi = 4095;
    n = $urandom_range(0, hi);
    f = $urandom_range(0, ((n > o) ? n : o) + 1);
    rq.req = REQ_EDIT;
    rq.first = f;
    rq.old_last = o;
    rq.new_last = n;
    send(rq);
    cnt = (f <= n) ? n - f + 1 : 0;
    if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, cnt + 1);
    for (int unsigned k = 0; k < cnt; k++) begin
      rq = noise_request();
      if ($urandom_range(0, 11) == 0) begin
        rq.req = REQ_LONGEST;
        rq.weight = pick_weight();
        send(rq);
        rq = noise_request();
      end
      rq.req = REQ_METRIC;
      rq.chars = pick_count();
      rq.tabs = pick_count();
      send(rq);
    end
  endtask

  // Output side: random stall stretches, with quiet spells while calm is set.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                                                   $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compares every accepted output transaction with the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (rst_ni && out_valid && !out_stall) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %p", got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer %0d: expected len %0d line %0d tabs %0d status %0d, got len %0d line %0d tabs %0d status %0d",
                     answers_seen, want.len, want.line, want.tabs, want.status,
                     got.len, got.line, got.tabs, got.status);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    request_t rq;
    int r;
    weight_cur = 1;
    clear_lines();

    // Directed rows. The table starts as one zero line with a tab weight of one.
    add_row(REQ_LONGEST, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    add_row(REQ_TABQ, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    add_row(REQ_TABQ, 0, 0, 0, 0, 0, 0, 4095, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(REQ_METRIC, 0, 0, 0, 65535, 65535, 0, 0, 1'b1, 0, 0, 0, STAT_NO_EDIT);
    add_row(3'd7, 4095, 4095, 4095, 65535, 65535, 255, 4095, 1'b1);
    add_row(REQ_EDIT, 0, 4095, 4095, 0, 0, 0, 0, 1'b1, 0, 0, 0, STAT_RANGE);
    // Grow to the full table, then measure line 0 at the widest counts.
    add_row(REQ_EDIT, 0, 0, 4095, 0, 0, 0, 0, 1'b1);
    add_row(REQ_METRIC, 0, 0, 0, 65535, 65535, 0, 0);
    // Query during the open edit at the widest weight forces a rescan.
    add_row(REQ_LONGEST, 0, 0, 0, 0, 0, 255, 0, 1'b1, 16711425, 0);
    // A new edit abandons the open one and leaves the maximum dirty.
    add_row(REQ_EDIT, 4095, 4095, 4095, 0, 0, 0, 0);
    add_row(REQ_METRIC, 0, 0, 0, 65535, 0, 0, 0);
    add_row(REQ_TABQ, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 65535);
    add_row(REQ_LONGEST, 0, 0, 0, 0, 0, 0, 0);
    // One line too many, then a shrink that measures nothing.
    add_row(REQ_EDIT, 0, 0, 1, 0, 0, 0, 0, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(REQ_EDIT, 1, 4095, 0, 0, 0, 0, 0);
    add_row(REQ_TABQ, 0, 0, 0, 0, 0, 0, 1, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(REQ_LONGEST, 0, 0, 0, 0, 0, 2, 0);
    add_row(REQ_RESET, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    add_row(REQ_LONGEST, 0, 0, 0, 0, 0, 2, 0, 1'b1);
    // A small edit session: grow to four lines and measure each, then shrink over the maximum.
    add_row(REQ_EDIT, 0, 0, 3, 0, 0, 0, 0);
    add_row(REQ_METRIC, 0, 0, 0, 5, 1, 0, 0);
    add_row(REQ_METRIC, 0, 0, 0, 2, 9, 0, 0);
    add_row(REQ_METRIC, 0, 0, 0, 7, 0, 0, 0);
    add_row(REQ_METRIC, 0, 0, 0, 1, 3, 0, 0);
    add_row(REQ_EDIT, 0, 2, 0, 0, 0, 0, 0);
    add_row(REQ_LONGEST, 0, 0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].ans);

    // Let the directed part settle before the random traffic starts.
    drain();

    while (items_sent < RANDOM_ITEMS + stim_rows.size()) begin
      if ($urandom_range(0, 199) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      rq = noise_request();
      if (line_cnt > 128 && $urandom_range(0, 3) == 0) begin
        rq.req = REQ_RESET;
        send(rq);
      end else if (r < 55) begin
        edit_session();
      end else if (r < 70) begin
        rq.req = REQ_LONGEST;
        rq.weight = pick_weight();
        send(rq);
      end else if (r < 82) begin
        rq.req = REQ_TABQ;
        if ($urandom_range(0, 4) != 0) rq.qline = $urandom_range(0, line_cnt - 1);
        send(rq);
      end else if (r < 84) begin
        rq.req = REQ_RESET;
        send(rq);
      end else if (r < 86) begin
        drain();
      end else begin
        // Noise: raw requests, mostly rejected edits, stray metrics or unknown codes.
        if (rq.req == REQ_RESET) rq.req = REQ_METRIC;
        send(rq);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests (%0d edit sessions opened), checked %0d answers.",
             items_sent, edits_opened, answers_seen);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d answers missing", mismatches, answers_due.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule
